[rtl/core/mtg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MT19937 generator package
// Constants, command codes and the output tempering function of the
// 32-bit Mersenne Twister.
// ----------------------------------------------------------------------------
package mtg_pkg;

	localparam int unsigned N_WORDS  = 624;
	localparam int unsigned M_OFFSET = 397;
	localparam int unsigned IDX_W    = 10;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [31:0]      word_t;

	localparam logic CMD_SEED = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	localparam word_t MATRIX_A = 32'h9908_B0DF;
	localparam word_t TMASK_B  = 32'h9D2C_5680;
	localparam word_t TMASK_C  = 32'hEFC6_0000;
	localparam word_t INIT_MUL = 32'd1812433253;
	localparam word_t UPPER    = 32'h8000_0000;
	localparam word_t LOWER    = 32'h7FFF_FFFF;

	localparam idx_t LAST_IDX = idx_t'(N_WORDS - 1);
	localparam idx_t WRAP_IDX = idx_t'(N_WORDS - M_OFFSET);
	localparam idx_t M_IDX    = idx_t'(M_OFFSET);

	function automatic word_t temper(input word_t y_in);
		word_t y;
		y = y_in;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TMASK_B);
		y = y ^ ((y << 15) & TMASK_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage
`default_nettype wire

[rtl/core/mersenne_twister_generator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MT19937 random number generator
// 32-bit Mersenne Twister with a 624-word state held in block memory.
//
// Input channel (in_valid/in_ready): one word carries a command and a seed.
//   A seed command writes the whole state, one word per cycle, and returns
//   nothing; in_ready stays low until the last word is written.
// Output channel (out_valid/out_ready): a draw command returns one tempered
//   32-bit word on random_word; out_valid rises once the twist state ends.
// The twist runs one word per draw: each draw reads the following word and
//   the word 397 places ahead from two mirrored memories in the cycle it is
//   accepted, then twists, writes back and tempers in the twist state once
//   the output register is free. A draw holds in_ready low until then.
// A draw accepted before any seed returns zero.
// Reset clears the control state; the memories are not cleared and are only
//   read after a seed has written all 624 words.
// A stalled receiver holds the finished word in the output register; a new
//   draw is still accepted and waits in the twist state until the output
//   register frees.
// ----------------------------------------------------------------------------
module mersenne_twister_generator (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire                 command,
	input  wire  mtg_pkg::word_t seed_value,
	output logic                out_valid,
	input  wire                 out_ready,
	output mtg_pkg::word_t      random_word
);
	import mtg_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SEED  = 2'd1;
	localparam logic [1:0] ST_TWIST = 2'd2;

	word_t mem_a [N_WORDS];
	word_t mem_b [N_WORDS];

	logic [1:0] state_q;
	idx_t       idx_q;
	idx_t       fill_q;
	logic       has_seed_q;
	word_t      cur_q;
	word_t      prev_q;
	word_t      rd_a_q;
	word_t      rd_b_q;
	logic       out_valid_q;
	word_t      out_word_q;

	logic  accept;
	logic  rd_en;
	idx_t  nxt_idx;
	idx_t  far_idx;
	logic  wr_en;
	idx_t  wr_addr;
	word_t wr_data;
	word_t mix;
	word_t twisted;
	word_t seed_next;
	word_t prev_mix;
	logic  out_free;
	logic  twist_go;

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign random_word = out_word_q;
	assign out_free    = !out_valid_q || out_ready;
	assign twist_go    = (state_q == ST_TWIST) && out_free;

	assign nxt_idx = (idx_q == LAST_IDX) ? '0 : idx_q + idx_t'(1);
	assign far_idx = (idx_q < WRAP_IDX) ? idx_q + M_IDX : idx_q - WRAP_IDX;
	assign rd_en   = accept && (command == CMD_DRAW) && has_seed_q;

	assign mix     = (cur_q & UPPER) | (rd_a_q & LOWER);
	assign twisted = rd_b_q ^ (mix >> 1) ^ (mix[0] ? MATRIX_A : '0);

	assign prev_mix  = prev_q ^ (prev_q >> 30);
	assign seed_next = INIT_MUL * prev_mix + word_t'(fill_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = twisted;
		if (accept && (command == CMD_SEED)) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = seed_value;
		end else if (state_q == ST_SEED) begin
			wr_en   = 1'b1;
			wr_addr = fill_q;
			wr_data = seed_next;
		end else if (twist_go && has_seed_q) begin
			wr_en   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[wr_addr] <= wr_data;
			mem_b[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem_a[nxt_idx];
			rd_b_q <= mem_b[far_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			fill_q      <= '0;
			has_seed_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (twist_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (command == CMD_SEED) begin
							fill_q  <= idx_t'(1);
							state_q <= ST_SEED;
						end else begin
							state_q <= ST_TWIST;
						end
					end
				end
				ST_SEED: begin
					fill_q <= fill_q + idx_t'(1);
					if (fill_q == LAST_IDX) begin
						idx_q      <= '0;
						has_seed_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_TWIST: begin
					if (out_free) begin
						if (has_seed_q) begin
							idx_q <= nxt_idx;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (command == CMD_SEED)) begin
			prev_q <= seed_value;
			cur_q  <= seed_value;
		end else if (state_q == ST_SEED) begin
			prev_q <= seed_next;
		end else if (twist_go && has_seed_q) begin
			cur_q <= rd_a_q;
		end
		if (twist_go) begin
			out_word_q <= has_seed_q ? temper(twisted) : '0;
		end
	end

endmodule
`default_nettype wire

[dv/mersenne_twister_generator_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MT19937 generator testbench
// Drives seed and draw words with random gaps and output stalls. A scoreboard
// keeps its own copy of the 624-word twister state and predicts every drawn
// word, then compares each returned word in order.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_test;
	import mtg_pkg::*;

	localparam int unsigned RANDOM_WORDS = 1800;
	localparam int unsigned STALL_LIMIT  = 4000;

	class draw_scoreboard;
		word_t       state_words[N_WORDS];
		int unsigned position;
		bit          seeded;
		word_t       pending_words[$];
		int unsigned mismatches;

		function new();
			position   = N_WORDS + 1;
			seeded     = 0;
			mismatches = 0;
		endfunction

		function void load_seed(input word_t seed);
			word_t p;
			state_words[0] = seed;
			for (int i = 1; i < N_WORDS; i++) begin
				p = state_words[i-1];
				state_words[i] = INIT_MUL * (p ^ (p >> 30)) + word_t'(i);
			end
			position = N_WORDS;
			seeded   = 1;
		endfunction

		function void regenerate();
			word_t x;
			word_t v;
			for (int i = 0; i < N_WORDS; i++) begin
				x = (state_words[i] & UPPER) | (state_words[(i + 1) % N_WORDS] & LOWER);
				v = state_words[(i + M_OFFSET) % N_WORDS] ^ (x >> 1);
				if (x[0]) begin
					v = v ^ MATRIX_A;
				end
				state_words[i] = v;
			end
			position = 0;
		endfunction

		function word_t shape_output(input word_t raw);
			word_t y;
			y = raw;
			y = y ^ (y >> 11);
			y = y ^ ((y << 7) & TMASK_B);
			y = y ^ ((y << 15) & TMASK_C);
			y = y ^ (y >> 18);
			return y;
		endfunction

		function void note_command(input logic cmd, input word_t seed);
			if (cmd == CMD_SEED) begin
				load_seed(seed);
			end else if (!seeded) begin
				pending_words.push_back('0);
			end else begin
				if (position >= N_WORDS) begin
					regenerate();
				end
				pending_words.push_back(shape_output(state_words[position]));
				position++;
			end
		endfunction

		function void check_word(input word_t actual);
			word_t expected;
			if (pending_words.size() == 0) begin
				$display("%0t: random_word %h arrived with none expected", $time, actual);
				mismatches++;
			end else begin
				expected = pending_words.pop_front();
				if (expected !== actual) begin
					$display("%0t: random_word expected %h, got %h", $time, expected, actual);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	logic  command;
	word_t seed_value;
	logic  out_valid;
	logic  out_ready;
	word_t random_word;

	draw_scoreboard sb = new();
	int unsigned    quiet_cycles;
	bit             sender_steady;
	bit             receiver_steady;

	mersenne_twister_generator u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.seed_value  (seed_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.random_word (random_word)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned pick_gap(input bit steady);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 65) begin
			return 0;
		end else if (roll < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic send_word(input logic cmd, input word_t seed);
		in_valid   = 1'b1;
		command    = cmd;
		seed_value = seed;
		do @(posedge clk); while (!in_ready);
		sb.note_command(cmd, seed);
		@(negedge clk);
	endtask

	task automatic idle_gap();
		int unsigned gap;
		if ($urandom_range(0, 149) == 0) begin
			sender_steady = ~sender_steady;
		end
		gap = pick_gap(sender_steady);
		if (gap > 0) begin
			in_valid   = 1'b0;
			command    = 1'($urandom_range(0, 1));
			seed_value = $urandom();
			repeat (gap) @(negedge clk);
		end
	endtask

	// hold the sender until every drawn word is back
	task automatic drain_hold();
		in_valid = 1'b0;
		while (sb.pending_words.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			int unsigned stall;
			@(negedge clk);
			if ($urandom_range(0, 199) == 0) begin
				receiver_steady = ~receiver_steady;
			end
			if (receiver_steady || $urandom_range(0, 5) != 0) begin
				out_ready = 1'b1;
			end else begin
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
					: $urandom_range(1, 3);
				out_ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			sb.check_word(random_word);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		quiet_cycles    = 0;
		sender_steady   = 0;
		receiver_steady = 0;
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		command         = CMD_DRAW;
		seed_value      = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// draws before any seed return zero
		send_word(CMD_DRAW, 32'h0000_0000);
		send_word(CMD_DRAW, 32'hFFFF_FFFF);
		send_word(CMD_SEED, 32'h0000_0000);
		send_word(CMD_DRAW, 32'h0000_0000);
		idle_gap();
		send_word(CMD_DRAW, 32'h5555_5555);
		send_word(CMD_SEED, 32'hFFFF_FFFF);
		send_word(CMD_DRAW, 32'hAAAA_AAAA);
		send_word(CMD_SEED, 32'd5489);
		for (int i = 0; i < 4; i++) begin
			send_word(CMD_DRAW, $urandom());
			idle_gap();
		end
		// reseed mid-stream rewinds to a full twist
		send_word(CMD_SEED, 32'd5489);
		send_word(CMD_DRAW, 32'h0000_0000);
		send_word(CMD_DRAW, 32'hFFFF_FFFF);
		send_word(CMD_SEED, 32'h8000_0000);
		send_word(CMD_DRAW, 32'h0000_0000);
		send_word(CMD_SEED, 32'h7FFF_FFFF);
		send_word(CMD_DRAW, 32'h0000_0000);
		send_word(CMD_SEED, 32'h0000_0001);
		send_word(CMD_DRAW, 32'hFFFF_FFFF);
		drain_hold();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			logic cmd;
			cmd = ($urandom_range(0, 399) == 0) ? CMD_SEED : CMD_DRAW;
			send_word(cmd, $urandom());
			idle_gap();
			if (n % 450 == 449) begin
				drain_hold();
			end
		end
		in_valid = 1'b0;

		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.pending_words.size() != 0) begin
			$display("%0t: %0d drawn words never returned", $time, sb.pending_words.size());
			sb.mismatches++;
		end
		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/mtg_pkg.sv
rtl/core/mersenne_twister_generator.sv
dv/mersenne_twister_generator_test.sv
